### hw/rtl/gbpt_pkg.sv
// ----------------------------------------------------------------------------
// gbpt_pkg
// Shared types and codes for the gain bucket priority table.
// ----------------------------------------------------------------------------
package gbpt_pkg;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_ERASE  = 3'd1;
    localparam logic [2:0] MODE_SETG   = 3'd2;
    localparam logic [2:0] MODE_INC    = 3'd3;
    localparam logic [2:0] MODE_DEC    = 3'd4;

    localparam logic [6:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RDP,
        S_CHK,
        S_UNL,
        S_SCAN,
        S_SCANW,
        S_LINK,
        S_LINK2,
        S_LINK3,
        S_TOP,
        S_TOP2,
        S_TOP3
    } t_state;

endpackage

### hw/rtl/gain_bucket_priority_table.sv
// ----------------------------------------------------------------------------
// gain_bucket_priority_table
// Gain bucket structure: one linked list of cells per gain value.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(CELLS, 2*GAIN_BOUND+1)
// addresses (1024 by default) with busy high. A transaction is taken when start
// is high and busy is low; busy then stays high until the result strobe.
// A sequencer walks the one-read one-write link memories one access at a
// time: it reads and checks the cell, unlinks it and links it into its new
// bucket as the mode needs, then looks up the top cell; that lookup is skipped
// when the table is left empty. When the highest bucket empties, a downward
// rescan visits the buckets in turn until one is in use or the lowest is reached.
// Results are shown for one cycle with o_strobe and cannot be held off.
module gain_bucket_priority_table #(
    parameter int CELLS      = 1024,
    parameter int GAIN_BOUND = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    input  logic [2:0]        i_mode,
    input  logic [9:0]        i_cell_req,
    input  logic signed [7:0] i_gain,
    input  logic [15:0]       i_size,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic              o_empty_res,
    output logic [9:0]        o_top_cell,
    output logic signed [7:0] o_top_gain,
    output logic [15:0]       o_top_size
);

    localparam int CW   = $clog2(CELLS);
    localparam int PW   = $clog2(CELLS + 1);
    localparam int NB   = 2 * GAIN_BOUND + 1;
    localparam int BW   = $clog2(NB);
    localparam int GW   = $clog2(GAIN_BOUND + 1) + 2;
    localparam int EW   = ((GW > 8) ? GW : 8) + 1;
    localparam int XW   = (CW > 10) ? CW : 10;
    localparam int CLRN = (CELLS > NB) ? CELLS : NB;
    localparam int CLRW = $clog2(CLRN);
    localparam logic [PW-1:0] NIL = PW'(CELLS);

    function automatic logic signed [GW-1:0] f_clamp(input logic [6:0] v);
        logic signed [GW-1:0] r;
        if (v == 7'd0) begin
            r = GW'(1);
        end else if (int'(v) > GAIN_BOUND) begin
            r = GW'(GAIN_BOUND);
        end else begin
            r = GW'(v);
        end
        return r;
    endfunction

    function automatic logic [BW-1:0] f_bidx(input logic signed [GW-1:0] g);
        logic signed [GW:0] s;
        s = (GW+1)'(g) + (GW+1)'(GAIN_BOUND);
        return s[BW-1:0];
    endfunction

    gbpt_pkg::t_state      r_state, n_state;
    logic [CLRW-1:0]       r_clr, n_clr;
    logic signed [GW-1:0]  r_lim, n_lim;
    logic signed [GW-1:0]  r_max, n_max;
    logic [PW-1:0]         r_count, n_count;
    logic [2:0]            r_mode, n_mode;
    logic [CW-1:0]         r_c, n_c;
    logic signed [EW-1:0]  r_g, n_g;
    logic [15:0]           r_sz, n_sz;
    logic                  r_valid, n_valid;
    logic signed [GW-1:0]  r_cg, n_cg;
    logic [PW-1:0]         r_cp, n_cp;
    logic [PW-1:0]         r_cn, n_cn;
    logic signed [GW-1:0]  r_ng, n_ng;
    logic                  r_erase, n_erase;
    gbpt_pkg::t_status     r_status, n_status;
    logic [CW-1:0]         r_tc, n_tc;
    logic                  r_strobe, n_strobe;
    logic [1:0]            r_o_status, n_o_status;
    logic                  r_o_empty, n_o_empty;
    logic [9:0]            r_o_cell, n_o_cell;
    logic signed [7:0]     r_o_gain, n_o_gain;
    logic [15:0]           r_o_size, n_o_size;

    logic                  pr_we, pr_wd, pr_rd;
    logic [CW-1:0]         pr_wa, pr_ra;
    logic                  gn_we;
    logic [CW-1:0]         gn_wa, gn_ra;
    logic [GW-1:0]         gn_wd, gn_rd;
    logic                  sz_we;
    logic [CW-1:0]         sz_wa, sz_ra;
    logic [15:0]           sz_wd, sz_rd;
    logic                  pv_we;
    logic [CW-1:0]         pv_wa, pv_ra;
    logic [PW-1:0]         pv_wd, pv_rd;
    logic                  nx_we;
    logic [CW-1:0]         nx_wa, nx_ra;
    logic [PW-1:0]         nx_wd, nx_rd;
    logic                  hd_we;
    logic [BW-1:0]         hd_wa, hd_ra;
    logic [PW-1:0]         hd_wd, hd_rd;
    logic                  tl_we;
    logic [BW-1:0]         tl_wa, tl_ra;
    logic [PW-1:0]         tl_wd, tl_rd;

    logic [XW-1:0]         w_cx;
    logic [XW-1:0]         w_tcx;
    logic signed [EW-1:0]  w_lx;
    logic signed [EW-1:0]  w_gx;
    logic signed [GW-1:0]  w_m1;
    logic [CW-1:0]         w_ti;
    logic signed [GW-1:0]  w_gs;

    gbpt_ram #(.DEPTH(CELLS), .WIDTH(1)) u_present (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(pr_wd),
        .i_raddr(pr_ra), .o_rdata(pr_rd)
    );
    gbpt_ram #(.DEPTH(CELLS), .WIDTH(GW)) u_gain (
        .i_clk(i_clk), .i_we(gn_we), .i_waddr(gn_wa), .i_wdata(gn_wd),
        .i_raddr(gn_ra), .o_rdata(gn_rd)
    );
    gbpt_ram #(.DEPTH(CELLS), .WIDTH(16)) u_size (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(sz_wa), .i_wdata(sz_wd),
        .i_raddr(sz_ra), .o_rdata(sz_rd)
    );
    gbpt_ram #(.DEPTH(CELLS), .WIDTH(PW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd)
    );
    gbpt_ram #(.DEPTH(CELLS), .WIDTH(PW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd)
    );
    gbpt_ram #(.DEPTH(NB), .WIDTH(PW)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd)
    );
    gbpt_ram #(.DEPTH(NB), .WIDTH(PW)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_rd)
    );

    assign w_cx  = XW'(i_cell_req);
    assign w_tcx = XW'(r_tc);
    assign w_lx  = EW'(r_lim);
    assign w_m1  = r_max - GW'(1);
    assign w_ti  = (tl_rd < NIL) ? tl_rd[CW-1:0] : '0;
    assign w_gs  = gn_rd;
    assign w_gx  = EW'(w_gs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbpt_pkg::S_CLR;
            r_clr    <= '0;
            r_lim    <= f_clamp(gbpt_pkg::CFG_RESET);
            r_max    <= -f_clamp(gbpt_pkg::CFG_RESET);
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_lim    <= n_lim;
            r_max    <= n_max;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_mode     <= n_mode;
        r_c        <= n_c;
        r_g        <= n_g;
        r_sz       <= n_sz;
        r_valid    <= n_valid;
        r_cg       <= n_cg;
        r_cp       <= n_cp;
        r_cn       <= n_cn;
        r_ng       <= n_ng;
        r_erase    <= n_erase;
        r_status   <= n_status;
        r_tc       <= n_tc;
        r_o_status <= n_o_status;
        r_o_empty  <= n_o_empty;
        r_o_cell   <= n_o_cell;
        r_o_gain   <= n_o_gain;
        r_o_size   <= n_o_size;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_lim      = r_lim;
        n_max      = r_max;
        n_count    = r_count;
        n_mode     = r_mode;
        n_c        = r_c;
        n_g        = r_g;
        n_sz       = r_sz;
        n_valid    = r_valid;
        n_cg       = r_cg;
        n_cp       = r_cp;
        n_cn       = r_cn;
        n_ng       = r_ng;
        n_erase    = r_erase;
        n_status   = r_status;
        n_tc       = r_tc;
        n_strobe   = 1'b0;
        n_o_status = r_o_status;
        n_o_empty  = r_o_empty;
        n_o_cell   = r_o_cell;
        n_o_gain   = r_o_gain;
        n_o_size   = r_o_size;

        pr_we = 1'b0; pr_wa = r_c; pr_wd = 1'b0; pr_ra = r_c;
        gn_we = 1'b0; gn_wa = r_c; gn_wd = r_ng; gn_ra = r_c;
        sz_we = 1'b0; sz_wa = r_c; sz_wd = r_sz; sz_ra = r_c;
        pv_we = 1'b0; pv_wa = r_c; pv_wd = tl_rd; pv_ra = r_c;
        nx_we = 1'b0; nx_wa = r_c; nx_wd = NIL; nx_ra = r_c;
        hd_we = 1'b0; hd_wa = f_bidx(r_cg); hd_wd = NIL; hd_ra = f_bidx(w_m1);
        tl_we = 1'b0; tl_wa = f_bidx(r_cg); tl_wd = NIL; tl_ra = f_bidx(r_ng);

        case (r_state)
            gbpt_pkg::S_CLR: begin
                pr_wa = r_clr[CW-1:0];
                hd_wa = r_clr[BW-1:0];
                tl_wa = r_clr[BW-1:0];
                pr_we = (int'(r_clr) < CELLS);
                hd_we = (int'(r_clr) < NB);
                tl_we = (int'(r_clr) < NB);
                if (r_clr == CLRW'(CLRN - 1)) begin
                    n_state = gbpt_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + CLRW'(1);
                end
            end
            gbpt_pkg::S_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_c     = w_cx[CW-1:0];
                    n_g     = EW'(i_gain);
                    n_sz    = i_size;
                    n_valid = (int'(i_cell_req) < CELLS);
                    n_state = gbpt_pkg::S_RDP;
                end
            end
            gbpt_pkg::S_RDP: begin
                n_state = gbpt_pkg::S_CHK;
            end
            gbpt_pkg::S_CHK: begin
                n_cg     = w_gs;
                n_cp     = pv_rd;
                n_cn     = nx_rd;
                n_status = gbpt_pkg::ST_OK;
                n_erase  = (r_mode == gbpt_pkg::MODE_ERASE);
                n_state  = gbpt_pkg::S_TOP;
                if (r_mode <= gbpt_pkg::MODE_DEC && !r_valid) begin
                    n_status = gbpt_pkg::ST_ABSENT;
                end else if (r_mode == gbpt_pkg::MODE_INSERT) begin
                    if (pr_rd) begin
                        n_status = gbpt_pkg::ST_DUP;
                    end else if (r_g < -w_lx || r_g > w_lx) begin
                        n_status = gbpt_pkg::ST_RANGE;
                    end else begin
                        pr_we   = 1'b1;
                        pr_wd   = 1'b1;
                        sz_we   = 1'b1;
                        n_count = r_count + PW'(1);
                        n_ng    = GW'(r_g);
                        n_state = gbpt_pkg::S_LINK;
                    end
                end else if (r_mode <= gbpt_pkg::MODE_DEC) begin
                    if (!pr_rd) begin
                        n_status = gbpt_pkg::ST_ABSENT;
                    end else if (r_mode == gbpt_pkg::MODE_ERASE) begin
                        n_state = gbpt_pkg::S_UNL;
                    end else if (r_mode == gbpt_pkg::MODE_SETG) begin
                        if (r_g < -w_lx || r_g > w_lx) begin
                            n_status = gbpt_pkg::ST_RANGE;
                        end else begin
                            n_ng    = GW'(r_g);
                            n_state = gbpt_pkg::S_UNL;
                        end
                    end else if (r_mode == gbpt_pkg::MODE_INC) begin
                        if (w_gx + EW'(1) > w_lx) begin
                            n_status = gbpt_pkg::ST_RANGE;
                        end else begin
                            n_ng    = w_gs + GW'(1);
                            n_state = gbpt_pkg::S_UNL;
                        end
                    end else begin
                        if (w_gx - EW'(1) < -w_lx) begin
                            n_status = gbpt_pkg::ST_RANGE;
                        end else begin
                            n_ng    = w_gs - GW'(1);
                            n_state = gbpt_pkg::S_UNL;
                        end
                    end
                end
            end
            gbpt_pkg::S_UNL: begin
                if (r_cp == NIL) begin
                    hd_we = 1'b1;
                    hd_wd = r_cn;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = r_cp[CW-1:0];
                    nx_wd = r_cn;
                end
                if (r_cn == NIL) begin
                    tl_we = 1'b1;
                    tl_wd = r_cp;
                end else begin
                    pv_we = 1'b1;
                    pv_wa = r_cn[CW-1:0];
                    pv_wd = r_cp;
                end
                if (r_erase) begin
                    pr_we   = 1'b1;
                    pr_wd   = 1'b0;
                    n_count = r_count - PW'(1);
                end
                if (r_cp == NIL && r_cn == NIL && r_cg == r_max) begin
                    n_state = gbpt_pkg::S_SCAN;
                end else begin
                    n_state = r_erase ? gbpt_pkg::S_TOP : gbpt_pkg::S_LINK;
                end
            end
            gbpt_pkg::S_SCAN: begin
                if (r_max == -r_lim) begin
                    n_state = r_erase ? gbpt_pkg::S_TOP : gbpt_pkg::S_LINK;
                end else begin
                    n_max   = w_m1;
                    n_state = gbpt_pkg::S_SCANW;
                end
            end
            gbpt_pkg::S_SCANW: begin
                if (hd_rd != NIL) begin
                    n_state = r_erase ? gbpt_pkg::S_TOP : gbpt_pkg::S_LINK;
                end else begin
                    n_state = gbpt_pkg::S_SCAN;
                end
            end
            gbpt_pkg::S_LINK: begin
                n_state = gbpt_pkg::S_LINK2;
            end
            gbpt_pkg::S_LINK2: begin
                gn_we = 1'b1;
                pv_we = 1'b1;
                pv_wd = tl_rd;
                tl_we = 1'b1;
                tl_wa = f_bidx(r_ng);
                tl_wd = PW'(r_c);
                if (tl_rd == NIL) begin
                    hd_we = 1'b1;
                    hd_wa = f_bidx(r_ng);
                    hd_wd = PW'(r_c);
                end else begin
                    nx_we = 1'b1;
                    nx_wa = tl_rd[CW-1:0];
                    nx_wd = PW'(r_c);
                end
                if (r_ng > r_max) begin
                    n_max = r_ng;
                end
                n_state = gbpt_pkg::S_LINK3;
            end
            gbpt_pkg::S_LINK3: begin
                nx_we   = 1'b1;
                nx_wd   = NIL;
                n_state = gbpt_pkg::S_TOP;
            end
            gbpt_pkg::S_TOP: begin
                tl_ra = f_bidx(r_max);
                if (r_count == '0) begin
                    n_strobe   = 1'b1;
                    n_o_status = r_status;
                    n_o_empty  = 1'b1;
                    n_o_cell   = '0;
                    n_o_gain   = '0;
                    n_o_size   = '0;
                    n_state    = gbpt_pkg::S_IDLE;
                end else begin
                    n_state = gbpt_pkg::S_TOP2;
                end
            end
            gbpt_pkg::S_TOP2: begin
                n_tc    = w_ti;
                gn_ra   = w_ti;
                sz_ra   = w_ti;
                n_state = gbpt_pkg::S_TOP3;
            end
            gbpt_pkg::S_TOP3: begin
                n_strobe   = 1'b1;
                n_o_status = r_status;
                n_o_empty  = 1'b0;
                n_o_cell   = w_tcx[9:0];
                n_o_gain   = w_gx[7:0];
                n_o_size   = sz_rd;
                n_state    = gbpt_pkg::S_IDLE;
            end
            default: begin
                n_state = gbpt_pkg::S_IDLE;
            end
        endcase

        // limit changes only while no cell is held
        if (i_cfg_we && r_count == '0) begin
            n_lim = f_clamp(i_cfg_data);
            n_max = -f_clamp(i_cfg_data);
        end
    end

    assign busy        = (r_state != gbpt_pkg::S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_o_status;
    assign o_empty_res = r_o_empty;
    assign o_top_cell  = r_o_cell;
    assign o_top_gain  = r_o_gain;
    assign o_top_size  = r_o_size;

endmodule

### hw/rtl/gbpt_ram.sv
// ----------------------------------------------------------------------------
// gbpt_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbpt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
